### sv/pmc_pkg.sv
package pmc_pkg;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PULSES_PER_UNIT = 2'd0,
    CFG_CHARGE_PER_UNIT = 2'd1,
    CFG_LOW_THRESHOLD   = 2'd2
  } cfg_idx_t;

  // Configuration reset values
  localparam logic [3:0] PPU_RST = 4'd5;
  localparam logic [7:0] CPU_RST = 8'd2;
  localparam logic [7:0] THR_RST = 8'd20;

  // Command codes reported with each result
  typedef enum logic [2:0] {
    CMD_NONE      = 3'd0,
    CMD_REPORT    = 3'd1,
    CMD_RELAY_ON  = 3'd2,
    CMD_RELAY_OFF = 3'd3,
    CMD_RECHARGE  = 3'd4,
    CMD_FACTORY   = 3'd5,
    CMD_UNKNOWN   = 3'd6
  } cmd_code_t;

  // Frame characters
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_TWO   = 8'h32;
  localparam logic [7:0] CH_C     = 8'h43;
  localparam logic [7:0] CH_E     = 8'h45;
  localparam logic [7:0] CH_F     = 8'h46;
  localparam logic [7:0] CH_N     = 8'h4E;
  localparam logic [7:0] CH_Q     = 8'h51;
  localparam logic [7:0] CH_R     = 8'h52;
  localparam logic [7:0] CH_T     = 8'h54;
  localparam logic [7:0] DIGIT_ZERO = 8'h30;
  localparam logic [8:0] RECHARGE_LIMIT = 9'd255;

  // Bytes after the start character
  localparam logic [2:0] FRAME_LEN = 3'd4;

  // Decoded frame actions
  typedef struct packed {
    cmd_code_t  code;
    logic       relay_connect;
    logic       relay_cut;
    logic       credit_wr;
    logic [7:0] credit_val;
    logic       counters_clr;
  } frm_dec_t;

endpackage

### sv/pmc_frame_dec.sv
module pmc_frame_dec import pmc_pkg::*; (
  input  logic [3:0][7:0] frame,
  input  logic [7:0]      credit,
  output frm_dec_t        dec
);

  logic [7:0] d1, d2, d3;
  logic [7:0] add;
  logic [8:0] sum;
  logic       is_req, is_on, is_off, is_fct;

  // Recharge amount, modulo 256; digits are not range checked
  always_comb begin
    d1  = frame[1] - DIGIT_ZERO;
    d2  = frame[2] - DIGIT_ZERO;
    d3  = frame[3] - DIGIT_ZERO;
    add = (d1 * 8'd100) + (d2 * 8'd10) + d3;
    sum = {1'b0, add} + {1'b0, credit};
  end

  // Fixed frame matches
  assign is_req = (frame[0] == CH_ONE) && (frame[1] == CH_R) &&
                  (frame[2] == CH_E)   && (frame[3] == CH_Q);
  assign is_on  = (frame[0] == CH_ONE) && (frame[1] == CH_TWO) &&
                  (frame[2] == CH_ONE) && (frame[3] == CH_N);
  assign is_off = (frame[0] == CH_ONE) && (frame[1] == CH_TWO) &&
                  (frame[2] == CH_ONE) && (frame[3] == CH_F);
  assign is_fct = (frame[0] == CH_ONE) && (frame[1] == CH_F) &&
                  (frame[2] == CH_C)   && (frame[3] == CH_T);

  // First match wins; relay on at zero balance falls through
  always_comb begin
    dec = '0;
    dec.code = CMD_UNKNOWN;
    dec.credit_val = sum[7:0];
    priority if (is_req) begin
      dec.code = CMD_REPORT;
    end else if (is_on && (credit != 8'd0)) begin
      dec.code = CMD_RELAY_ON;
      dec.relay_connect = 1'b1;
    end else if (is_off) begin
      dec.code = CMD_RELAY_OFF;
      dec.relay_cut = 1'b1;
    end else if (frame[0] == CH_C) begin
      dec.code = CMD_RECHARGE;
      dec.relay_connect = 1'b1;
      dec.credit_wr = (sum < RECHARGE_LIMIT);
    end else if (is_fct) begin
      dec.code = CMD_FACTORY;
      dec.counters_clr = 1'b1;
    end else begin
      dec.code = CMD_UNKNOWN;
    end
  end

endmodule

### sv/prepaid_meter_controller_core.sv
// Prepaid energy meter controller.
// Input channel (in_valid / in_stall): one transaction is either a meter
// pulse (in_func = 0) or one received command byte (in_func = 1, in_rx_byte).
// Output channel (out_valid / out_stall): exactly one result transaction per
// input transaction, in order: relay drive, balance, billed units, pulse
// count, decoded command code, report request and low-balance alert.
// Config channel (cfg_valid / cfg_ready, cfg_index, cfg_data): index 0 pulses
// per unit, 1 charge per unit, 2 low threshold. cfg_ready is always high;
// write only while the block is idle.
// Path: an accepted transaction is held in the input register, and its result
// is registered in the result register once out_free lets it move on.
// Throughput: one transaction per cycle while out_stall is low; the whole
// update is one pass of logic between the input register and the result register.
// Stall: while out_stall holds a result, the input register keeps its
// transaction and in_stall rises once that register is also full.
// Reset: registers return to their defaults, balance and counters are zero,
// relay connected, alert armed, no frame in progress. Frame bytes are not
// cleared; they are always written before use.
module prepaid_meter_controller_core import pmc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  // input channel
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_func,
  input  logic [7:0]           in_rx_byte,
  // result channel
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_relay_on,
  output logic [7:0]           out_balance,
  output logic [7:0]           out_units,
  output logic [3:0]           out_pulse_count,
  output logic [2:0]           out_command_code,
  output logic                 out_report_request,
  output logic                 out_low_alert,
  // configuration
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data
);

  // Config registers
  logic [3:0] ppu_r;
  logic [7:0] cpu_r;
  logic [7:0] thr_r;

  // Input register
  logic       s1_vld_r;
  logic       s1_func_r;
  logic [7:0] s1_byte_r;

  // Meter state
  logic [2:0][7:0] frame_r;
  logic [2:0]      pos_r,      pos_nxt;
  logic [3:0]      pulse_r,    pulse_nxt;
  logic [7:0]      units_r,    units_nxt;
  logic [7:0]      credit_r,   credit_nxt;
  logic            cut_r,      cut_nxt;
  logic            alert_off_r, alert_off_nxt;

  // Result register
  logic       out_vld_r;
  logic       out_relay_r;
  logic [7:0] out_balance_r;
  logic [7:0] out_units_r;
  logic [3:0] out_pulse_r;
  cmd_code_t  out_code_r,   code_nxt;
  logic       out_report_r, report_nxt;
  logic       out_alert_r,  alert_nxt;

  logic            out_free, s1_go, in_acc;
  logic            frame_we;
  logic [1:0]      frame_wa;
  logic [3:0]      pulse_inc;
  logic [3:0][7:0] dec_frame;
  frm_dec_t        dec;

  // Handshake
  assign out_free  = !out_vld_r || !out_stall;
  assign s1_go     = s1_vld_r && out_free;
  assign in_stall  = s1_vld_r && !out_free;
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ppu_r <= PPU_RST;
      cpu_r <= CPU_RST;
      thr_r <= THR_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_PULSES_PER_UNIT: ppu_r <= cfg_data[3:0];
        CFG_CHARGE_PER_UNIT: cpu_r <= cfg_data;
        CFG_LOW_THRESHOLD:   thr_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= in_acc || in_stall;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_func_r <= in_func;
      s1_byte_r <= in_rx_byte;
    end
  end

  // Frame decode: three stored bytes plus the byte at hand
  assign dec_frame[2:0] = frame_r;
  assign dec_frame[3]   = s1_byte_r;

  pmc_frame_dec u_dec (
    .frame  (dec_frame),
    .credit (credit_r),
    .dec    (dec)
  );

  // Next state for one transaction
  always_comb begin
    pos_nxt       = pos_r;
    pulse_nxt     = pulse_r;
    units_nxt     = units_r;
    credit_nxt    = credit_r;
    cut_nxt       = cut_r;
    alert_off_nxt = alert_off_r;
    code_nxt      = CMD_NONE;
    report_nxt    = 1'b0;
    alert_nxt     = 1'b0;
    frame_we      = 1'b0;
    frame_wa      = pos_r[1:0] - 2'd1;
    pulse_inc     = pulse_r + 4'd1;

    if (!s1_func_r) begin
      // meter pulse, bill a unit when the count is reached
      if (pulse_inc >= ppu_r) begin
        pulse_nxt  = 4'd0;
        units_nxt  = units_r + 8'd1;
        credit_nxt = (credit_r > cpu_r) ? (credit_r - cpu_r) : 8'd0;
      end else begin
        pulse_nxt = pulse_inc;
      end
    end else if ((pos_r == 3'd0) || (pos_r > FRAME_LEN)) begin
      // hunt for the start character
      pos_nxt = (s1_byte_r == CH_STAR) ? 3'd1 : 3'd0;
    end else if (pos_r != FRAME_LEN) begin
      frame_we = 1'b1;
      pos_nxt  = pos_r + 3'd1;
    end else begin
      // last byte: act on the whole frame
      pos_nxt    = 3'd0;
      code_nxt   = dec.code;
      report_nxt = (dec.code == CMD_REPORT);
      if (dec.relay_connect) cut_nxt = 1'b0;
      if (dec.relay_cut)     cut_nxt = 1'b1;
      if (dec.credit_wr)     credit_nxt = dec.credit_val;
      if (dec.counters_clr) begin
        pulse_nxt  = 4'd0;
        units_nxt  = 8'd0;
        credit_nxt = 8'd0;
      end
    end

    // low-balance alert fires once, re-arms above the threshold
    if ((credit_nxt < thr_r) && !alert_off_r) begin
      alert_off_nxt = 1'b1;
      alert_nxt     = 1'b1;
    end else if (credit_nxt > thr_r) begin
      alert_off_nxt = 1'b0;
    end

    // empty balance disconnects the load
    if (credit_nxt == 8'd0) cut_nxt = 1'b1;
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= 3'd0;
      pulse_r     <= 4'd0;
      units_r     <= 8'd0;
      credit_r    <= 8'd0;
      cut_r       <= 1'b0;
      alert_off_r <= 1'b0;
    end else if (s1_go) begin
      pos_r       <= pos_nxt;
      pulse_r     <= pulse_nxt;
      units_r     <= units_nxt;
      credit_r    <= credit_nxt;
      cut_r       <= cut_nxt;
      alert_off_r <= alert_off_nxt;
    end
  end

  // Frame byte store
  always_ff @(posedge clk) begin
    if (s1_go && frame_we) begin
      frame_r[frame_wa] <= s1_byte_r;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= s1_go || (out_vld_r && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      out_relay_r   <= !cut_nxt;
      out_balance_r <= credit_nxt;
      out_units_r   <= units_nxt;
      out_pulse_r   <= pulse_nxt;
      out_code_r    <= code_nxt;
      out_report_r  <= report_nxt;
      out_alert_r   <= alert_nxt;
    end
  end

  assign out_valid          = out_vld_r;
  assign out_relay_on       = out_relay_r;
  assign out_balance        = out_balance_r;
  assign out_units          = out_units_r;
  assign out_pulse_count    = out_pulse_r;
  assign out_command_code   = out_code_r;
  assign out_report_request = out_report_r;
  assign out_low_alert      = out_alert_r;

  // Checks
  a_zero_cuts_relay: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && (out_balance_r == 8'd0)) |-> !out_relay_r)
    else $error("relay connected at zero balance");

  a_report_code: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_report_r) |-> (out_code_r == CMD_REPORT))
    else $error("report request without report command");

  a_frame_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= FRAME_LEN)
    else $error("frame position out of range");

  a_alert_disarms: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_go && alert_nxt) |=> alert_off_r)
    else $error("alert fired but stayed armed");

  a_alert_once: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_go && alert_off_r) |-> !alert_nxt)
    else $error("alert fired while disarmed");

endmodule
